### sv/kct_pkg.sv
package kct_pkg;

	localparam int ID_W            = 32;
	localparam int COORD_W         = 24;
	localparam int RANGE_W         = COORD_W - 1;
	localparam int RSQ_W           = 2 * RANGE_W;
	localparam int CNT_OUT_W       = 6;
	localparam int MAX_ENTRIES_DEF = 32;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;
	localparam logic [1:0] ACT_QUERY  = 2'd3;

	localparam logic [2:0] STAT_UPDATED = 3'd0;
	localparam logic [2:0] STAT_ADDED   = 3'd1;
	localparam logic [2:0] STAT_FULL    = 3'd2;
	localparam logic [2:0] STAT_REMOVED = 3'd3;
	localparam logic [2:0] STAT_ABSENT  = 3'd4;
	localparam logic [2:0] STAT_CLEARED = 3'd5;
	localparam logic [2:0] STAT_MATCH   = 3'd6;
	localparam logic [2:0] STAT_NOMATCH = 3'd7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]                action;
		logic [ID_W-1:0]           entity_id;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [RANGE_W-1:0]        query_range;
	} req_t;

	typedef struct packed {
		logic [2:0]                status;
		logic [ID_W-1:0]           found_id;
		logic signed [COORD_W-1:0] found_x;
		logic signed [COORD_W-1:0] found_y;
		logic signed [COORD_W-1:0] found_z;
		logic [CNT_OUT_W-1:0]      entry_count;
		logic                      last;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]           id;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} entry_t;

	typedef struct packed {
		op_t                       op;
		logic [ID_W-1:0]           entity_id;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [RSQ_W-1:0]          rsq;
	} cmd_t;

endpackage

### sv/keyed_caster_table_range_query.sv
// Path: an accepted request passes through the input register and then the queue to the scan engine.
// Throughput: the scan engine takes one request at a time; insert, remove and query scan every stored
// entry through the table memory read port, one entry per cycle unless a stalled result holds the scan;
// clear, and any request on an empty table, reads no entry.
// Queries emit one result per cycle while matches stream; a stalled result holds the scan.
// Reset: asynchronous, active low; clears the entry count and all control state, no memory sweep.
module keyed_caster_table_range_query import kct_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic f_valid;
	logic f_ready;
	cmd_t f_cmd;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	kct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	kct_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_cmd)
	);

	kct_back #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

### sv/kct_front.sv
module kct_front import kct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic cmd_valid,
	input  logic cmd_ready,
	output cmd_t cmd
);

	logic cmd_valid_q;
	cmd_t cmd_q;
	op_t  op_d;

	assign req_ready = !cmd_valid_q || cmd_ready;
	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;

	always_comb begin
		unique case (req.action)
			ACT_INSERT: op_d = OP_INSERT;
			ACT_REMOVE: op_d = OP_REMOVE;
			ACT_CLEAR:  op_d = OP_CLEAR;
			ACT_QUERY:  op_d = OP_QUERY;
			default:    op_d = OP_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (req_ready) begin
			cmd_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_q.op        <= op_d;
			cmd_q.entity_id <= req.entity_id;
			cmd_q.pos_x     <= req.pos_x;
			cmd_q.pos_y     <= req.pos_y;
			cmd_q.pos_z     <= req.pos_z;
			cmd_q.rsq       <= RSQ_W'(req.query_range) * RSQ_W'(req.query_range);
		end
	end

endmodule

### sv/kct_queue.sv
module kct_queue import kct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              push;
	logic              pop;

	assign push_ready = fill_q != (QPTR_W + 1)'(QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### sv/kct_back.sv
module kct_back import kct_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW    = $clog2(MAX_ENTRIES + 1);
	localparam int SQ_W  = 2 * COORD_W;
	localparam int SUM_W = SQ_W + 2;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_SCAN = 3'b010,
		BK_DONE = 3'b100
	} bk_state_t;

	function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		logic signed [COORD_W:0] d;
		d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
		abs_diff = d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
	endfunction

	entry_t            slot_mem [MAX_ENTRIES];
	bk_state_t         state_q;
	cmd_t              cmd_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_d;
	logic [CW-1:0]     rd_idx_q;
	logic [CW-1:0]     w_idx_q;
	logic              found_q;
	logic [AW-1:0]     found_idx_q;
	logic              v_s1;
	logic [AW-1:0]     idx_s1;
	entry_t            ent_s1;
	logic              v_s2;
	entry_t            ent_s2;
	logic [SQ_W-1:0]   sq_s2 [3];
	logic              pend_v_q;
	entry_t            pend_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	rsp_t              rsp_d;
	logic              emit;
	logic              adv;
	logic              pop;
	logic              issue;
	logic              scan_end;
	logic              id_hit_s1;
	logic              hit_s2;
	logic [SUM_W-1:0]  sum_s2;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	entry_t            wr_data;
	logic [COORD_W-1:0] ad_x;
	logic [COORD_W-1:0] ad_y;
	logic [COORD_W-1:0] ad_z;

	assign adv       = !rsp_valid_q || rsp_ready;
	assign cmd_ready = (state_q == BK_IDLE) && adv;
	assign pop       = cmd_ready && cmd_valid;
	assign rd_addr   = rd_idx_q[AW-1:0];
	assign issue     = (state_q == BK_SCAN) && (cmd_q.op != OP_CLEAR) && (rd_idx_q < count_q);
	assign scan_end  = (state_q == BK_SCAN) && !issue && !v_s1 && !v_s2;
	assign id_hit_s1 = ent_s1.id == cmd_q.entity_id;
	assign sum_s2    = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
	assign hit_s2    = v_s2 && (sum_s2 <= SUM_W'(cmd_q.rsq));
	assign ad_x      = abs_diff(ent_s1.x, cmd_q.pos_x);
	assign ad_y      = abs_diff(ent_s1.y, cmd_q.pos_y);
	assign ad_z      = abs_diff(ent_s1.z, cmd_q.pos_z);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		emit    = 1'b0;
		rsp_d   = '0;
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = ent_s1;
		count_d = count_q;
		unique case (state_q)
			BK_SCAN: begin
				if (cmd_q.op == OP_REMOVE && v_s1 && !id_hit_s1) begin
					wr_en   = 1'b1;
					wr_addr = w_idx_q[AW-1:0];
				end
				if (hit_s2 && pend_v_q) begin
					emit           = 1'b1;
					rsp_d.status   = STAT_MATCH;
					rsp_d.found_id = pend_q.id;
					rsp_d.found_x  = pend_q.x;
					rsp_d.found_y  = pend_q.y;
					rsp_d.found_z  = pend_q.z;
				end
			end
			BK_DONE: begin
				emit       = 1'b1;
				rsp_d.last = 1'b1;
				wr_data    = '{id: cmd_q.entity_id, x: cmd_q.pos_x, y: cmd_q.pos_y,
					z: cmd_q.pos_z};
				unique case (cmd_q.op)
					OP_INSERT: begin
						if (found_q) begin
							wr_en        = 1'b1;
							wr_addr      = found_idx_q;
							rsp_d.status = STAT_UPDATED;
						end else if (count_q < CNT_MAX) begin
							wr_en        = 1'b1;
							wr_addr      = count_q[AW-1:0];
							count_d      = count_q + 1'b1;
							rsp_d.status = STAT_ADDED;
						end else begin
							rsp_d.status = STAT_FULL;
						end
					end
					OP_REMOVE: begin
						if (found_q) begin
							count_d      = w_idx_q;
							rsp_d.status = STAT_REMOVED;
						end else begin
							rsp_d.status = STAT_ABSENT;
						end
					end
					OP_CLEAR: begin
						count_d      = '0;
						rsp_d.status = STAT_CLEARED;
					end
					OP_QUERY: begin
						if (pend_v_q) begin
							rsp_d.status   = STAT_MATCH;
							rsp_d.found_id = pend_q.id;
							rsp_d.found_x  = pend_q.x;
							rsp_d.found_y  = pend_q.y;
							rsp_d.found_z  = pend_q.z;
						end else begin
							rsp_d.status = STAT_NOMATCH;
						end
					end
					default: rsp_d.status = STAT_NOMATCH;
				endcase
			end
			default: ;
		endcase
		rsp_d.entry_count = CNT_OUT_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			w_idx_q     <= '0;
			found_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			pend_v_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= emit;
			count_q     <= count_d;
			v_s1        <= issue;
			v_s2        <= v_s1 && (cmd_q.op == OP_QUERY);
			unique case (state_q)
				BK_IDLE: begin
					if (cmd_valid) begin
						state_q  <= BK_SCAN;
						rd_idx_q <= '0;
						w_idx_q  <= '0;
						found_q  <= 1'b0;
						pend_v_q <= 1'b0;
					end
				end
				BK_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (cmd_q.op == OP_REMOVE && v_s1 && !id_hit_s1) begin
						w_idx_q <= w_idx_q + 1'b1;
					end
					if ((cmd_q.op == OP_INSERT || cmd_q.op == OP_REMOVE) && v_s1 && id_hit_s1) begin
						found_q <= 1'b1;
					end
					if (hit_s2) begin
						pend_v_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= BK_DONE;
					end
				end
				BK_DONE: begin
					state_q  <= BK_IDLE;
					pend_v_q <= 1'b0;
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (pop) begin
				cmd_q <= cmd;
			end
			if (issue) begin
				idx_s1 <= rd_addr;
			end
			if (v_s1 && id_hit_s1) begin
				found_idx_q <= idx_s1;
			end
			ent_s2   <= ent_s1;
			sq_s2[0] <= SQ_W'(ad_x) * SQ_W'(ad_x);
			sq_s2[1] <= SQ_W'(ad_y) * SQ_W'(ad_y);
			sq_s2[2] <= SQ_W'(ad_z) * SQ_W'(ad_z);
			if (hit_s2) begin
				pend_q <= ent_s2;
			end
			if (emit) begin
				rsp_q <= rsp_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (wr_en) begin
				slot_mem[wr_addr] <= wr_data;
			end
			if (issue) begin
				ent_s1 <= slot_mem[rd_addr];
			end
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("entry count above table depth");

	a_rd_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SCAN |-> rd_idx_q <= count_q)
		else $error("scan index past entry count");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SCAN |-> w_idx_q <= rd_idx_q)
		else $error("compaction write ahead of read");

	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_IDLE |-> !pend_v_q)
		else $error("held match left over between requests");

endmodule
